// File: design/vpcu_pkg.sv
package vpcu_pkg;

  localparam logic OP_LOAD     = 1'b0;
  localparam logic OP_CLASSIFY = 1'b1;

  localparam logic [2:0] REG_RADIUS      = 3'd0;
  localparam logic [2:0] REG_MIN_MATCHES = 3'd1;
  localparam logic [2:0] REG_WIDTH       = 3'd2;
  localparam logic [2:0] REG_HEIGHT      = 3'd3;
  localparam logic [2:0] REG_PERSIST     = 3'd4;
  localparam logic [2:0] REG_CLEAR       = 3'd5;
  localparam logic [2:0] REG_ALARM       = 3'd6;

  localparam int          CFG_W       = 19;
  localparam int          TALLY_W     = 19;
  localparam logic [18:0] TALLY_MAX   = 19'h7FFFF;
  localparam logic [18:0] ALARM_RESET = 19'd4000;

  // Neighbour offset: 0 -> -1, 1 -> 0, 2 -> +1 (picks above 8 use offset 0).
  typedef logic [1:0] offs_t;
  localparam offs_t OFF_NEG  = 2'd0;
  localparam offs_t OFF_ZERO = 2'd1;
  localparam offs_t OFF_POS  = 2'd2;

  function automatic offs_t pick_offset(input logic [3:0] pick);
    offs_t o;
    unique case (pick)
      4'd0, 4'd3, 4'd5: o = OFF_NEG;
      4'd2, 4'd4, 4'd7: o = OFF_POS;
      default:          o = OFF_ZERO;
    endcase
    return o;
  endfunction

endpackage

// File: design/vibe_pixel_classify_update.sv
// Per-pixel background classifier with in-place model update.
// Input channel in_*: one request per pixel, taken when in_valid & !in_stall.
// A load request writes in_pixel_value into one sample slot; a classify
// request compares the pixel with every stored sample and updates the model.
// Result channel out_*: one result per request (foreground, alarm, frame_end),
// held in an output register while out_stall is high.
// Sequencing: a load writes its sample slot in the read state and then
// waits in the done state for the result. A classify reads its slots one a
// cycle, as the sample memory has one port, and counts each read as it
// returns; the self and neighbour write-backs follow in their own states.
// One request is in flight at a time; the next one is accepted in the cycle
// after its result has moved into the output register. A stalled result
// holds the sequencer.
// Reset: the foreground-count memory is cleared by a pass over all
// MAX_ROWS * MAX_COLS entries, during which no request is accepted
// (configuration writes still land). Tally resets to zero, alarm re-arms.
// Sample memory content is undefined until loaded.
module vibe_pixel_classify_update
  import vpcu_pkg::*;
#(
  parameter int NUM_SLOTS = 20,
  parameter int MAX_ROWS  = 512,
  parameter int MAX_COLS  = 512
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_write_en,
  input  logic [2:0]               cfg_index,
  input  logic [CFG_W-1:0]         cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_operation,
  input  logic [8:0]               in_pixel_row,
  input  logic [8:0]               in_pixel_col,
  input  logic [7:0]               in_pixel_value,
  input  logic [7:0]               in_self_draw,
  input  logic [4:0]               in_self_slot,
  input  logic [7:0]               in_neighbour_draw,
  input  logic [3:0]               in_neighbour_row_pick,
  input  logic [3:0]               in_neighbour_col_pick,
  input  logic [4:0]               in_neighbour_slot,
  input  logic                     in_frame_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     out_foreground,
  output logic                     out_alarm,
  output logic                     out_frame_end
);

  localparam int RW   = $clog2(MAX_ROWS);
  localparam int CW   = $clog2(MAX_COLS);
  localparam int SW   = $clog2(NUM_SLOTS);
  localparam int PIXW = RW + CW;
  localparam int NPIX = MAX_ROWS * MAX_COLS;
  localparam int MW   = $clog2(NUM_SLOTS + 1);
  localparam int DEPTH = NUM_SLOTS * NPIX;
  localparam int AW   = $clog2(DEPTH);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_DEC   = 3'd3;
  localparam logic [2:0] ST_NB    = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // configuration
  logic [7:0]  radius_r, persist_r, clear_r;
  logic [4:0]  min_r;
  logic [9:0]  width_r, height_r;
  logic [18:0] alarm_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 8'd20;
      min_r       <= 5'd2;
      width_r     <= 10'd512;
      height_r    <= 10'd512;
      persist_r   <= 8'd50;
      clear_r     <= 8'd90;
      alarm_cnt_r <= ALARM_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        REG_RADIUS:      radius_r    <= cfg_data[7:0];
        REG_MIN_MATCHES: min_r       <= cfg_data[4:0];
        REG_WIDTH:       width_r     <= cfg_data[9:0];
        REG_HEIGHT:      height_r    <= cfg_data[9:0];
        REG_PERSIST:     persist_r   <= cfg_data[7:0];
        REG_CLEAR:       clear_r     <= cfg_data[7:0];
        REG_ALARM:       alarm_cnt_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // memories
  logic [7:0] sample_mem [DEPTH];
  logic [7:0] count_mem  [NPIX];

  // request registers
  logic [2:0]  state_r, state_nxt;
  logic        op_r, last_r, inside_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic [7:0]  pix_r, sdraw_r, ndraw_r;
  logic [4:0]  sslot_r, nslot_r;
  logic [3:0]  rpick_r, cpick_r;
  logic [SW:0] slot_r;
  logic        rd_pend_r;
  logic [MW-1:0] match_r;
  logic [PIXW:0] clr_r;
  logic [7:0]  smp_q, cnt_q;
  logic [TALLY_W-1:0] tally_r;
  logic        armed_r;
  logic        out_fg_r, out_al_r, out_fe_r, out_v_r;
  logic        fg_r, al_r;

  logic accept, out_free;
  assign out_free = !out_v_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);

  // neighbour coordinates, clamped to the active image
  function automatic logic [11:0] clampc(input logic [11:0] pos, input offs_t o,
                                         input logic [9:0] size, input int mx);
    logic [12:0] lim, s, v;
    s = {3'd0, size};
    if (s == 13'd0) s = 13'd1;
    if (s > 13'(mx)) s = 13'(mx);
    lim = s - 13'd1;
    v = {1'b0, pos};
    if (o == OFF_POS) v = v + 13'd1;
    if (o == OFF_NEG) v = (v == 13'd0) ? 13'd0 : v - 13'd1;
    if (v > lim) v = lim;
    return v[11:0];
  endfunction

  logic [11:0] nr_w, nc_w;
  assign nr_w = clampc(12'(row_r), pick_offset(rpick_r), height_r, MAX_ROWS);
  assign nc_w = clampc(12'(col_r), pick_offset(cpick_r), width_r, MAX_COLS);

  function automatic logic [AW-1:0] saddr(input logic [SW:0] s, input logic [RW-1:0] r,
                                          input logic [CW-1:0] c);
    return AW'((s * NPIX) + {r, c});
  endfunction

  // sample memory port control
  logic          s_we;
  logic [AW-1:0] s_addr;
  logic          c_we;
  logic [PIXW-1:0] c_addr;
  logic [7:0]    c_wd;
  logic          bg;
  logic [7:0]    cnt_inc;
  assign bg      = (match_r >= MW'(min_r));
  assign cnt_inc = cnt_q + 8'd1;

  always_comb begin
    s_we   = 1'b0;
    s_addr = saddr(slot_r, row_r, col_r);
    c_we   = 1'b0;
    c_addr = {row_r, col_r};
    c_wd   = 8'd0;
    unique case (state_r)
      ST_CLEAR: begin
        c_we   = 1'b1;
        c_addr = clr_r[PIXW-1:0];
      end
      ST_READ: begin
        if (!op_r && inside_r) begin
          s_addr = saddr((SW+1)'(sslot_r), row_r, col_r);
          s_we   = (32'(sslot_r) < NUM_SLOTS);
        end
      end
      ST_DEC: begin
        s_addr = saddr((SW+1)'(sslot_r), row_r, col_r);
        c_we   = inside_r;
        if (bg) begin
          c_wd = 8'd0;
          s_we = inside_r && (sdraw_r == 8'd0) && (32'(sslot_r) < NUM_SLOTS);
        end else begin
          c_wd = cnt_inc;
          s_we = inside_r && (cnt_inc > persist_r) && (sdraw_r == 8'd0)
                 && (32'(sslot_r) < NUM_SLOTS);
        end
      end
      ST_NB: begin
        s_addr = saddr((SW+1)'(nslot_r), nr_w[RW-1:0], nc_w[CW-1:0]);
        s_we   = inside_r && fg_r == 1'b0 && (ndraw_r == 8'd0)
                 && (32'(nslot_r) < NUM_SLOTS);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s_we) sample_mem[s_addr] <= pix_r;
    smp_q <= sample_mem[s_addr];
    if (c_we) count_mem[c_addr] <= c_wd;
    cnt_q <= count_mem[c_addr];
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_r == (PIXW+1)'(NPIX - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_READ;
      ST_READ: begin
        if (!op_r || !inside_r) state_nxt = ST_DONE;
        else if (slot_r == (SW+1)'(NUM_SLOTS)) state_nxt = ST_DEC;
      end
      ST_DEC:   state_nxt = ST_NB;
      ST_NB:    state_nxt = ST_DONE;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  logic [8:0] d;
  assign d = (smp_q > pix_r) ? {1'b0, smp_q - pix_r} : {1'b0, pix_r - smp_q};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
      tally_r <= '0;
      armed_r <= 1'b1;
      out_v_r <= 1'b0;
      slot_r  <= '0;
      rd_pend_r <= 1'b0;
      match_r <= '0;
      fg_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // drop a taken result unless a new one loads this cycle
      if (out_v_r && !out_stall && state_r != ST_DONE) out_v_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: clr_r <= clr_r + 1'b1;
        ST_IDLE: begin
          slot_r    <= '0;
          rd_pend_r <= 1'b0;
          match_r   <= '0;
          fg_r      <= 1'b0;
        end
        ST_READ: begin
          // slot read issued this cycle returns next cycle; count it then
          if (rd_pend_r && (d < {1'b0, radius_r})) match_r <= match_r + 1'b1;
          rd_pend_r <= (slot_r < (SW+1)'(NUM_SLOTS));
          if (slot_r < (SW+1)'(NUM_SLOTS)) slot_r <= slot_r + 1'b1;
        end
        ST_DEC: begin
          if (inside_r && !bg) begin
            fg_r <= 1'b1;
            if (cnt_inc > clear_r) tally_r <= '0;
            else if (cnt_inc > persist_r && tally_r < TALLY_MAX)
              tally_r <= tally_r + 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            out_v_r  <= 1'b1;
            out_fg_r <= fg_r;
            out_fe_r <= last_r;
            out_al_r <= last_r && armed_r && (tally_r > alarm_cnt_r);
            if (last_r) begin
              if (tally_r > alarm_cnt_r && armed_r) armed_r <= 1'b0;
              tally_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // hold the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= in_operation;
      last_r   <= in_frame_last;
      inside_r <= (32'(in_pixel_row) < MAX_ROWS) && (32'(in_pixel_col) < MAX_COLS);
      row_r    <= RW'(in_pixel_row);
      col_r    <= CW'(in_pixel_col);
      pix_r    <= in_pixel_value;
      sdraw_r  <= in_self_draw;
      ndraw_r  <= in_neighbour_draw;
      sslot_r  <= in_self_slot;
      nslot_r  <= in_neighbour_slot;
      rpick_r  <= in_neighbour_row_pick;
      cpick_r  <= in_neighbour_col_pick;
    end
  end

  assign out_valid      = out_v_r;
  assign out_foreground = out_fg_r;
  assign out_alarm      = out_al_r;
  assign out_frame_end  = out_fe_r;

endmodule
